[design/ccsc_pkg.sv]
// ----------------------------------------------------------------------------
// ccsc_pkg
// Shared types and constants of the 2x2 chi-square classifier pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsc_pkg;

  localparam int CNT_W   = 16;
  localparam int ID_W    = 24;
  localparam int FREQ_W  = 23;
  localparam int RATIO_W = 30;
  localparam int CHI_W   = 32;

  localparam logic [2:0] REG_BAND_TOTAL  = 3'd0;
  localparam logic [2:0] REG_GRAND_TOTAL = 3'd1;
  localparam logic [2:0] REG_THRESH_LOW  = 3'd2;
  localparam logic [2:0] REG_THRESH_MID  = 3'd3;
  localparam logic [2:0] REG_THRESH_HIGH = 3'd4;

  localparam logic [31:0] THRESH_LOW_RST  = 32'd251724;
  localparam logic [31:0] THRESH_MID_RST  = 32'd434898;
  localparam logic [31:0] THRESH_HIGH_RST = 32'd709624;

  localparam logic [1:0] DIR_EQUAL  = 2'd0;
  localparam logic [1:0] DIR_HIGHER = 2'd1;
  localparam logic [1:0] DIR_LOWER  = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_P05  = 2'd1;
  localparam logic [1:0] LEVEL_P01  = 2'd2;
  localparam logic [1:0] LEVEL_P001 = 2'd3;

  localparam logic [29:0] RATIO_CAP   = 30'd655359344;
  localparam logic [29:0] RATIO_CAPP1 = 30'd655359345;
  localparam logic [22:0] FO_SMALL    = 23'd6;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             bad;
    logic             zm;
    logic             dir_ok;
    logic [1:0]       dir;
    logic             bt_zero;
    logic             other_zero;
    logic [38:0]      fb_num;
    logic [38:0]      fo_num;
    logic [CNT_W-1:0] bt;
    logic [CNT_W-1:0] other;
  } hdr_t;

  typedef struct packed {
    hdr_t hdr;
    logic sat;
  } chi_side_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             bad;
    logic             zm;
    logic             dir_ok;
    logic [1:0]       dir;
    logic [CHI_W-1:0] chi;
  } frq_side_t;

  typedef struct packed {
    frq_side_t         f;
    logic [FREQ_W-1:0] fb;
    logic [FREQ_W-1:0] fo;
    logic              force_cap;
  } rat_side_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [FREQ_W-1:0]  freq_other;
    logic [FREQ_W-1:0]  freq_band;
    logic [CHI_W-1:0]   chi_square;
    logic [1:0]         direction;
    logic [1:0]         level;
    logic [ID_W-1:0]    result_id;
  } res_data_t;

  typedef struct packed {
    res_data_t  data;
    logic [1:0] status;
  } res_t;

endpackage

`default_nettype wire

[design/ccsc_div_cell.sv]
// ----------------------------------------------------------------------------
// ccsc_div_cell
// One restoring division step that resolves one quotient bit per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsc_div_cell #(
  parameter int REM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int Q_W    = 8,
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              valid_in,
  input  wire logic [REM_W-1:0]  rem_in,
  input  wire logic [DEN_W-1:0]  den_in,
  input  wire logic [Q_W-1:0]    q_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   valid_out,
  output logic [REM_W-1:0]       rem_out,
  output logic [DEN_W-1:0]       den_out,
  output logic [Q_W-1:0]         q_out,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int CMP_W = ((REM_W > DEN_W + SHIFT) ? REM_W : DEN_W + SHIFT) + 1;

  logic [CMP_W-1:0] trial;
  logic [CMP_W-1:0] rem_ext;
  logic             ge;
  logic [REM_W-1:0] rem_next;

  assign trial    = {{(CMP_W-DEN_W){1'b0}}, den_in} << SHIFT;
  assign rem_ext  = {{(CMP_W-REM_W){1'b0}}, rem_in};
  assign ge       = rem_ext >= trial;
  assign rem_next = ge ? REM_W'(rem_ext - trial) : rem_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ce) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_out  <= rem_next;
      den_out  <= den_in;
      q_out    <= {q_in[Q_W-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

[design/ccsc_out_skid.sv]
// ----------------------------------------------------------------------------
// ccsc_out_skid
// Output register with a skid entry that decouples the pipeline from stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsc_out_skid (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  ccsc_pkg::res_t    in_data,
  output logic              ce,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ccsc_pkg::res_t    out_data
);
  import ccsc_pkg::*;

  logic skid_valid;
  res_t skid;
  logic take;

  assign ce   = !skid_valid;
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= skid_valid ? skid : in_data;
    end else if (in_valid && !skid_valid) begin
      skid <= in_data;
    end
  end

endmodule

`default_nettype wire

[design/contingency_chi_square_classifier.sv]
// ----------------------------------------------------------------------------
// contingency_chi_square_classifier
// 2x2 chi-square test of one term against a band of length bins.
// ----------------------------------------------------------------------------
// Input beats on the s_ channel carry a term number and its two counts; each
// one yields exactly one result beat on the m_ channel, in order. Band and
// grand totals and the three thresholds are set through cfg_we, cfg_index
// and cfg_data; the user must write them only while no beat is in flight,
// as the block does not enforce it. The datapath is one pipeline: seven
// stages build the contingency table and the chi-square numerator, then
// rows of division cells resolve one quotient bit per stage: 32 for the
// chi-square, 23 for both frequencies, two stages for the ratio cap test
// and 30 for the ratio. One beat is accepted every cycle while s_tready is
// high. When the receiver stalls, the output register holds its beat and a
// skid entry takes one more; the pipeline then freezes and s_tready drops
// until the skid entry drains. Reset empties the pipeline and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module contingency_chi_square_classifier (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // term_id[23:0], term_in_band[39:24], term_total[55:40]
  input  wire logic [55:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // result_id[23:0], level[25:24], direction[27:26], chi_square[59:28],
  // freq_band[82:60], freq_other[105:83], ratio[135:106]
  output logic [135:0]      m_tdata,
  // status[1:0]
  output logic [1:0]        m_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import ccsc_pkg::*;

  logic [15:0] band_total, grand_total;
  logic [31:0] thresh_low, thresh_mid, thresh_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_total  <= '0;
      grand_total <= '0;
      thresh_low  <= THRESH_LOW_RST;
      thresh_mid  <= THRESH_MID_RST;
      thresh_high <= THRESH_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAND_TOTAL:  band_total  <= cfg_data[15:0];
        REG_GRAND_TOTAL: grand_total <= cfg_data[15:0];
        REG_THRESH_LOW:  thresh_low  <= cfg_data;
        REG_THRESH_MID:  thresh_mid  <= cfg_data;
        REG_THRESH_HIGH: thresh_high <= cfg_data;
        default: ;
      endcase
    end
  end

  logic ce;
  assign s_tready = ce;

  // Stage 1: capture.
  logic        v1;
  logic [23:0] id1;
  logic [15:0] a1, t1, bt1, n1;

  // Stage 1 combinational table.
  logic [17:0] sum1;
  logic        bad1, zm1;
  logic [15:0] b1, c1, d1, other1, nt1;
  logic [22:0] fbn1, fon1;

  assign sum1   = {2'b0, t1} + {2'b0, bt1} - {2'b0, a1};
  assign bad1   = (a1 > t1) || (a1 > bt1) || (sum1 > {2'b0, n1});
  assign b1     = t1 - a1;
  assign c1     = bt1 - a1;
  assign d1     = n1 - t1 - c1;
  assign other1 = n1 - bt1;
  assign nt1    = n1 - t1;
  assign zm1    = (t1 == '0) || (nt1 == '0) || (bt1 == '0) || (other1 == '0);
  assign fbn1   = 23'(a1) * 23'd100;
  assign fon1   = 23'(b1) * 23'd100;

  // Stage 2 products.
  logic        v2;
  hdr_t        hdr2;
  hdr_t        hdr2d;
  logic [15:0] n2;
  logic [31:0] lhs2, rhs2, ad2, bc2, dena2, denb2;

  always_comb begin
    hdr2d     = hdr2;
    hdr2d.dir = (lhs2 > rhs2) ? DIR_HIGHER : ((lhs2 < rhs2) ? DIR_LOWER : DIR_EQUAL);
  end

  // Stage 3 difference and denominator.
  logic        v3;
  hdr_t        hdr3;
  logic [15:0] n3;
  logic [31:0] diff3;
  logic [63:0] den3;

  // Stage 4 square.
  logic        v4;
  hdr_t        hdr4;
  logic [15:0] n4;
  logic [63:0] den4, dsq4;

  // Stage 5 partial products.
  logic        v5;
  hdr_t        hdr5;
  logic [63:0] den5;
  logic [47:0] plo5, phi5;

  // Stage 6 numerator.
  logic        v6;
  hdr_t        hdr6;
  logic [63:0] den6;
  logic [79:0] num6;

  // Stage 7 saturation test.
  logic        v7;
  chi_side_t   side7;
  logic [63:0] den7;
  logic [95:0] rem7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      id1 <= s_tdata[23:0];
      a1  <= s_tdata[39:24];
      t1  <= s_tdata[55:40];
      bt1 <= band_total;
      n1  <= grand_total;

      hdr2.id         <= id1;
      hdr2.bad        <= bad1;
      hdr2.zm         <= zm1;
      hdr2.dir_ok     <= (bt1 != '0) && (other1 != '0);
      hdr2.dir        <= DIR_EQUAL;
      hdr2.bt_zero    <= (bt1 == '0);
      hdr2.other_zero <= (other1 == '0);
      hdr2.fb_num     <= {fbn1, 16'b0};
      hdr2.fo_num     <= {fon1, 16'b0};
      hdr2.bt         <= bt1;
      hdr2.other      <= other1;
      n2    <= n1;
      lhs2  <= 32'(a1) * 32'(other1);
      rhs2  <= 32'(b1) * 32'(bt1);
      ad2   <= 32'(a1) * 32'(d1);
      bc2   <= 32'(b1) * 32'(c1);
      dena2 <= 32'(t1) * 32'(nt1);
      denb2 <= 32'(bt1) * 32'(other1);

      hdr3  <= hdr2d;
      n3    <= n2;
      diff3 <= (ad2 > bc2) ? (ad2 - bc2) : (bc2 - ad2);
      den3  <= 64'(dena2) * 64'(denb2);

      hdr4 <= hdr3;
      n4   <= n3;
      den4 <= den3;
      dsq4 <= 64'(diff3) * 64'(diff3);

      hdr5 <= hdr4;
      den5 <= den4;
      plo5 <= 48'(n4) * 48'(dsq4[31:0]);
      phi5 <= 48'(n4) * 48'(dsq4[63:32]);

      hdr6 <= hdr5;
      den6 <= den5;
      num6 <= {phi5, 32'b0} + 80'(plo5);

      side7.hdr <= hdr6;
      side7.sat <= num6 >= {den6, 16'b0};
      den7 <= den6;
      rem7 <= {num6, 16'b0};
    end
  end

  // Chi-square division row.
  logic        cv   [0:32];
  logic [95:0] crem [0:32];
  logic [63:0] cden [0:32];
  logic [31:0] cq   [0:32];
  chi_side_t   cside[0:32];

  assign cv[0]    = v7;
  assign crem[0]  = rem7;
  assign cden[0]  = den7;
  assign cq[0]    = '0;
  assign cside[0] = side7;

  for (genvar i = 0; i < 32; i++) begin : g_chi
    ccsc_div_cell #(
      .REM_W(96), .DEN_W(64), .Q_W(32), .SHIFT(31 - i), .SIDE_W($bits(chi_side_t))
    ) u_cell (
      .clk(clk), .rst(rst), .ce(ce),
      .valid_in(cv[i]), .rem_in(crem[i]), .den_in(cden[i]), .q_in(cq[i]),
      .side_in(cside[i]),
      .valid_out(cv[i+1]), .rem_out(crem[i+1]), .den_out(cden[i+1]), .q_out(cq[i+1]),
      .side_out(cside[i+1])
    );
  end

  hdr_t        hdr_c;
  logic [31:0] chi_c;
  frq_side_t   fside0;

  assign hdr_c = cside[32].hdr;
  assign chi_c = (hdr_c.bad || hdr_c.zm) ? '0 : (cside[32].sat ? '1 : cq[32]);
  assign fside0 = '{id: hdr_c.id, bad: hdr_c.bad, zm: hdr_c.zm, dir_ok: hdr_c.dir_ok,
                    dir: hdr_c.dir, chi: chi_c};

  // Frequency division rows, band and outside the band side by side.
  logic        fv   [0:23];
  logic [38:0] frem [0:23];
  logic [15:0] fden [0:23];
  logic [22:0] fq   [0:23];
  frq_side_t   fside[0:23];
  logic [38:0] orem [0:23];
  logic [15:0] oden [0:23];
  logic [22:0] oq   [0:23];

  assign fv[0]    = cv[32];
  assign frem[0]  = hdr_c.fb_num;
  assign fden[0]  = hdr_c.bt;
  assign fq[0]    = '0;
  assign fside[0] = fside0;
  assign orem[0]  = hdr_c.fo_num;
  assign oden[0]  = hdr_c.other;
  assign oq[0]    = '0;

  logic        bz [0:23];
  logic        oz [0:23];
  assign bz[0] = hdr_c.bt_zero;
  assign oz[0] = hdr_c.other_zero;

  for (genvar i = 0; i < 23; i++) begin : g_frq
    ccsc_div_cell #(
      .REM_W(39), .DEN_W(16), .Q_W(23), .SHIFT(22 - i), .SIDE_W($bits(frq_side_t))
    ) u_band (
      .clk(clk), .rst(rst), .ce(ce),
      .valid_in(fv[i]), .rem_in(frem[i]), .den_in(fden[i]), .q_in(fq[i]),
      .side_in(fside[i]),
      .valid_out(fv[i+1]), .rem_out(frem[i+1]), .den_out(fden[i+1]), .q_out(fq[i+1]),
      .side_out(fside[i+1])
    );
    ccsc_div_cell #(
      .REM_W(39), .DEN_W(16), .Q_W(23), .SHIFT(22 - i), .SIDE_W(2)
    ) u_other (
      .clk(clk), .rst(rst), .ce(ce),
      .valid_in(fv[i]), .rem_in(orem[i]), .den_in(oden[i]), .q_in(oq[i]),
      .side_in({bz[i], oz[i]}),
      .valid_out(), .rem_out(orem[i+1]), .den_out(oden[i+1]), .q_out(oq[i+1]),
      .side_out({bz[i+1], oz[i+1]})
    );
  end

  logic [22:0] fb_f, fo_f;
  assign fb_f = bz[23] ? '0 : fq[23];
  assign fo_f = oz[23] ? '0 : oq[23];

  // Ratio cap test over two stages.
  logic        rv1, rv2;
  frq_side_t   rs1;
  logic [22:0] fb_r1, fo_r1;
  logic [52:0] prod_r1;
  logic        small_r1;
  rat_side_t   rside2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv1 <= 1'b0;
      rv2 <= 1'b0;
    end else if (ce) begin
      rv1 <= fv[23];
      rv2 <= rv1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rs1      <= fside[23];
      fb_r1    <= fb_f;
      fo_r1    <= fo_f;
      prod_r1  <= 53'(fo_f) * 53'(RATIO_CAPP1);
      small_r1 <= fo_f <= FO_SMALL;

      rside2.f         <= rs1;
      rside2.fb        <= fb_r1;
      rside2.fo        <= fo_r1;
      rside2.force_cap <= small_r1 || ({14'b0, fb_r1, 16'b0} >= prod_r1);
    end
  end

  // Ratio division row.
  logic        qv   [0:30];
  logic [38:0] qrem [0:30];
  logic [22:0] qden [0:30];
  logic [29:0] qq   [0:30];
  rat_side_t   qside[0:30];

  assign qv[0]    = rv2;
  assign qrem[0]  = {rside2.fb, 16'b0};
  assign qden[0]  = rside2.fo;
  assign qq[0]    = '0;
  assign qside[0] = rside2;

  for (genvar i = 0; i < 30; i++) begin : g_rat
    ccsc_div_cell #(
      .REM_W(39), .DEN_W(23), .Q_W(30), .SHIFT(29 - i), .SIDE_W($bits(rat_side_t))
    ) u_cell (
      .clk(clk), .rst(rst), .ce(ce),
      .valid_in(qv[i]), .rem_in(qrem[i]), .den_in(qden[i]), .q_in(qq[i]),
      .side_in(qside[i]),
      .valid_out(qv[i+1]), .rem_out(qrem[i+1]), .den_out(qden[i+1]), .q_out(qq[i+1]),
      .side_out(qside[i+1])
    );
  end

  rat_side_t fin;
  res_t      res;
  logic [1:0] lvl;
  logic [1:0] dirv;

  assign fin = qside[30];

  always_comb begin
    if (fin.f.zm) begin
      lvl = LEVEL_NONE;
    end else if (fin.f.chi >= thresh_high) begin
      lvl = LEVEL_P001;
    end else if (fin.f.chi >= thresh_mid) begin
      lvl = LEVEL_P01;
    end else if (fin.f.chi >= thresh_low) begin
      lvl = LEVEL_P05;
    end else begin
      lvl = LEVEL_NONE;
    end
    if (fin.f.dir_ok) begin
      dirv = fin.f.dir;
    end else begin
      dirv = (fin.fb > fin.fo) ? DIR_HIGHER : ((fin.fb < fin.fo) ? DIR_LOWER : DIR_EQUAL);
    end
    res = '0;
    res.data.result_id = fin.f.id;
    if (fin.f.bad) begin
      res.status = STATUS_BAD;
    end else begin
      res.status          = fin.f.zm ? STATUS_ZERO : STATUS_OK;
      res.data.level      = lvl;
      res.data.direction  = dirv;
      res.data.chi_square = fin.f.chi;
      res.data.freq_band  = fin.fb;
      res.data.freq_other = fin.fo;
      res.data.ratio      = fin.force_cap ? RATIO_CAP : qq[30];
    end
  end

  res_t out_res;

  ccsc_out_skid u_out (
    .clk(clk), .rst(rst),
    .in_valid(qv[30]), .in_data(res), .ce(ce),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(out_res)
  );

  assign m_tdata = out_res.data;
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire

[design/ccsc_checker.sv]
// ----------------------------------------------------------------------------
// ccsc_checker
// Port-level checks of the chi-square classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata,
  input wire logic [1:0]   m_tuser
);
  import ccsc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_BAD |-> m_tdata[135:24] == '0)
    else $error("inconsistent counts gave nonzero fields");

  a_zero_marginal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_ZERO |-> m_tdata[25:24] == LEVEL_NONE &&
      m_tdata[59:28] == '0)
    else $error("zero marginal gave a statistic");

endmodule

bind contingency_chi_square_classifier ccsc_checker u_ccsc_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

`default_nettype wire

[verif/contingency_chi_square_classifier_test.sv]
// ----------------------------------------------------------------------------
// contingency_chi_square_classifier_test
// Self-checking testbench for the 2x2 chi-square classifier.
// ----------------------------------------------------------------------------
// An initial block queues term beats phase by phase and rewrites the band
// and grand totals and the thresholds between phases while the pipeline is
// empty. A clocked driver feeds the queue into the input channel with random
// gaps, and a clocked monitor stalls the result channel at random and checks
// every result beat against a prediction made when its input beat was taken.
// ----------------------------------------------------------------------------
`default_nettype none

module contingency_chi_square_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccsc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int FRAC_BITS_SH = 16;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] in_band;
    logic [ID_W-1:0]  id;
  } term_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  logic [15:0] band_cfg, grand_cfg;
  logic [31:0] thr_low_cfg, thr_mid_cfg, thr_high_cfg;

  term_t pending_terms[$];
  res_t  expected_results[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  bit    no_idle = 1'b0;

  contingency_chi_square_classifier dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic res_t classify_term(term_t tm);
    res_t        r;
    logic [63:0] a, t, bt, n, b, c, d, other, lhs, rhs, fb, fo, ad, bc, diff, ratio;
    logic [127:0] num, den, q;
    r = '0;
    r.data.result_id = tm.id;
    a = 64'(tm.in_band);
    t = 64'(tm.total);
    bt = 64'(band_cfg);
    n = 64'(grand_cfg);
    if (a > t || a > bt || t + bt - a > n) begin
      r.status = STATUS_BAD;
      return r;
    end
    b = t - a;
    c = bt - a;
    d = n - t - c;
    other = n - bt;
    lhs = a * other;
    rhs = b * bt;
    fb = (bt != 0) ? ((64'd100 * a) << FRAC_BITS_SH) / bt : 64'd0;
    fo = (other != 0) ? ((64'd100 * b) << FRAC_BITS_SH) / other : 64'd0;
    r.data.freq_band = fb[22:0];
    r.data.freq_other = fo[22:0];
    if (bt != 0 && other != 0)
      r.data.direction = (lhs > rhs) ? DIR_HIGHER : (lhs < rhs) ? DIR_LOWER : DIR_EQUAL;
    else
      r.data.direction = (fb > fo) ? DIR_HIGHER : (fb < fo) ? DIR_LOWER : DIR_EQUAL;
    if (fo * 64'd10000 <= (64'd1 << FRAC_BITS_SH)) begin
      ratio = 64'(RATIO_CAP);
    end else begin
      ratio = (fb << FRAC_BITS_SH) / fo;
      if (ratio > 64'(RATIO_CAP)) ratio = 64'(RATIO_CAP);
    end
    r.data.ratio = ratio[29:0];
    if (t == 0 || n == t || bt == 0 || other == 0) begin
      r.status = STATUS_ZERO;
      return r;
    end
    ad = a * d;
    bc = b * c;
    diff = (ad > bc) ? ad - bc : bc - ad;
    num = ((128'(n) * 128'(diff) * 128'(diff)) << FRAC_BITS_SH);
    den = 128'(t) * 128'(n - t) * 128'(bt) * 128'(other);
    q = num / den;
    r.data.chi_square = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    if (r.data.chi_square >= thr_high_cfg) r.data.level = LEVEL_P001;
    else if (r.data.chi_square >= thr_mid_cfg) r.data.level = LEVEL_P01;
    else if (r.data.chi_square >= thr_low_cfg) r.data.level = LEVEL_P05;
    else r.data.level = LEVEL_NONE;
    r.status = STATUS_OK;
    return r;
  endfunction

  logic  drive_next;
  term_t next_term;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      drive_next = s_tvalid && !s_tready;
      if (s_tvalid && s_tready)
        expected_results.push_back(classify_term(term_t'(s_tdata)));
      if (!drive_next) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_terms.size() > 0) begin
          next_term = pending_terms.pop_front();
          s_tdata <= next_term;
          drive_next = 1'b1;
          in_gap = pick_gap();
        end
      end
      s_tvalid <= drive_next;
    end
  end

  res_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.data = res_data_t'(m_tdata);
        got.status = m_tuser;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat id=%0d", got.data.result_id);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch id exp=%0d got=%0d",
                       want.data.result_id, got.data.result_id,
                       " | lvl %0d/%0d", want.data.level, got.data.level,
                       " dir %0d/%0d", want.data.direction, got.data.direction,
                       " chi %0h/%0h", want.data.chi_square, got.data.chi_square,
                       " fb %0h/%0h", want.data.freq_band, got.data.freq_band,
                       " fo %0h/%0h", want.data.freq_other, got.data.freq_other,
                       " ratio %0h/%0h", want.data.ratio, got.data.ratio,
                       " st %0d/%0d", want.status, got.status);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_BAND_TOTAL:  band_cfg = val[15:0];
      REG_GRAND_TOTAL: grand_cfg = val[15:0];
      REG_THRESH_LOW:  thr_low_cfg = val;
      REG_THRESH_MID:  thr_mid_cfg = val;
      default:         thr_high_cfg = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_totals(int bt, int n, logic [31:0] tl, logic [31:0] tm, logic [31:0] th);
    write_reg(REG_BAND_TOTAL, bt);
    write_reg(REG_GRAND_TOTAL, n);
    write_reg(REG_THRESH_LOW, tl);
    write_reg(REG_THRESH_MID, tm);
    write_reg(REG_THRESH_HIGH, th);
  endtask

  task automatic add_term(logic [23:0] id, logic [15:0] a, logic [15:0] t);
    term_t tm;
    tm.id = id;
    tm.in_band = a;
    tm.total = t;
    pending_terms.push_back(tm);
  endtask

  task automatic add_random_terms(int count);
    int bt, other, a, b;
    for (int i = 0; i < count; i++) begin
      bt = band_cfg;
      other = grand_cfg - band_cfg;
      if (other < 0) other = 0;
      if ($urandom_range(0, 9) < 8) begin
        a = $urandom_range(0, bt);
        b = $urandom_range(0, other);
        if ($urandom_range(0, 3) == 0) begin
          a = (bt > 0) ? $urandom_range(bt - ((bt > 3) ? 3 : bt), bt) : 0;
          b = $urandom_range(0, (other > 3) ? 3 : other);
        end
        add_term(24'($urandom_range(0, 9999999)), 16'(a), 16'(a + b));
      end else begin
        add_term(24'($urandom_range(0, 9999999)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic drain();
    while (pending_terms.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(negedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    band_cfg = 16'd0;
    grand_cfg = 16'd0;
    thr_low_cfg = THRESH_LOW_RST;
    thr_mid_cfg = THRESH_MID_RST;
    thr_high_cfg = THRESH_HIGH_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_term(24'd0, 16'd0, 16'd0);
    add_term(24'd9999999, 16'd0, 16'd1);
    add_term(24'd5, 16'd1, 16'd1);
    drain();

    set_totals(20, 50, THRESH_LOW_RST, THRESH_MID_RST, THRESH_HIGH_RST);
    add_term(24'd1, 16'd0, 16'd0);
    add_term(24'd2, 16'd20, 16'd20);
    add_term(24'd3, 16'd20, 16'd50);
    add_term(24'd4, 16'd0, 16'd30);
    add_term(24'd5, 16'd10, 16'd25);
    add_term(24'd6, 16'd8, 16'd20);
    add_term(24'd7, 16'd21, 16'd25);
    add_term(24'd8, 16'd5, 16'd3);
    add_term(24'd9, 16'd0, 16'd31);
    add_term(24'd10, 16'd20, 16'd21);
    add_term(24'd11, 16'd65535, 16'd65535);
    add_term(24'd12, 16'd1, 16'd49);
    drain();

    set_totals(65535, 65535, 0, 0, 0);
    add_term(24'd9999999, 16'd65535, 16'd65535);
    add_term(24'd13, 16'd0, 16'd0);
    add_term(24'd14, 16'd1, 16'd1);
    drain();

    set_totals(30000, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_term(24'd15, 16'd30000, 16'd30000);
    add_term(24'd16, 16'd0, 16'd35535);
    add_term(24'd17, 16'd1, 16'd65534);
    add_term(24'd18, 16'd15000, 16'd32767);
    drain();

    set_totals(1, 1, 1, 2, 3);
    add_random_terms(60);
    drain();

    set_totals(20, 50, THRESH_LOW_RST, THRESH_MID_RST, THRESH_HIGH_RST);
    no_idle = 1'b1;
    add_random_terms(150);
    drain();
    no_idle = 1'b0;

    set_totals(100, 1000, 65536, 131072, 262144);
    add_random_terms(160);
    drain();

    set_totals(30000, 65535, THRESH_LOW_RST, THRESH_MID_RST, THRESH_HIGH_RST);
    add_random_terms(160);
    drain();

    set_totals(3, 7, 0, 32'h8000_0000, 32'hFFFF_FFFF);
    add_random_terms(140);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(REG_GRAND_TOTAL, $urandom_range(1, 65535));
      write_reg(REG_BAND_TOTAL, $urandom_range(0, grand_cfg));
      write_reg(REG_THRESH_LOW, $urandom_range(0, 400000));
      write_reg(REG_THRESH_MID, thr_low_cfg + $urandom_range(0, 400000));
      write_reg(REG_THRESH_HIGH, thr_mid_cfg + $urandom_range(0, 800000));
      add_random_terms(140);
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
